### rtl/core/fcs_pkg.sv
// Shared types and constants of the FIFO counting semaphore.
`timescale 1ns / 1ps
package fcs_pkg;

  // Payload widths of the request and response words.
  localparam int unsigned IdW    = 4;
  localparam int unsigned CountW = 8;
  localparam int unsigned WaitW  = 5;

  // Largest token count the semaphore holds.
  localparam logic [CountW-1:0] MaxTokens = 8'd255;

  typedef enum logic {
    OpAcquire = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatQueued    = 2'd1,
    StatDropped   = 2'd2,
    StatSaturated = 2'd3
  } status_e;

  typedef enum logic {
    SIdle = 1'b0,
    SExec = 1'b1
  } state_e;

  // Commands from the semaphore core to the wait queue.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

### rtl/core/fcs_if.sv
// Request and response channel interfaces of the FIFO counting semaphore.
`timescale 1ns / 1ps
interface fcs_req_if
  import fcs_pkg::*;
;
  logic           valid;
  logic           ready;
  logic           opcode;
  logic [IdW-1:0] requester_id;

  modport source (output valid, output opcode, output requester_id, input ready);
  modport sink   (input valid, input opcode, input requester_id, output ready);
endinterface

interface fcs_rsp_if
  import fcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [IdW-1:0]    grant_id;
  logic [1:0]        status;
  logic [CountW-1:0] tokens_left;
  logic [WaitW-1:0]  waiting_count;

  modport source (
    output valid, output granted, output grant_id, output status,
    output tokens_left, output waiting_count, input ready
  );
  modport sink (
    input valid, input granted, input grant_id, input status,
    input tokens_left, input waiting_count, output ready
  );
endinterface

### rtl/core/fifo_counting_semaphore_unit.sv
// Top level of the FIFO counting semaphore.
//
// Requests arrive as words on req_i: an acquire or a release and the id of
// the requester. Each request gives exactly one response word on rsp_o with
// the grant, the granted id, a status code and the token and waiter counts
// after the request.
// A request is registered when it is accepted and is executed from those
// registers once the output register is free and the wait queue memory has
// delivered the id at the head of the queue from its registered read port.
// A request is executed only after the previous one has finished, so the
// head read always sees every earlier push and pop. The block takes no new
// request until the one it holds has been executed, and the response is
// registered in the output register.
// The response sits in an output register. When the receiver stalls, the
// block still accepts one more request and holds it until the output
// register is free.
// Reset clears the token count and empties the queue. A write on the
// configuration port, made while the block is idle, loads the token count
// (saturated to the maximum) and empties the queue.
`timescale 1ns / 1ps
module fifo_counting_semaphore_unit
  import fcs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  fcs_req_if.sink           req_i,
  fcs_rsp_if.source         rsp_o
);

  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1);

  state_e            state_q, state_d;
  op_e               op_q;
  logic [IdW-1:0]    id_q;
  logic [CountW-1:0] count_q, count_d;

  logic              out_valid_q;
  logic              granted_q, granted_d;
  logic [IdW-1:0]    grant_id_q, grant_id_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] tokens_q;
  logic [WaitW-1:0]  waiting_q, waiting_d;

  q_ctrl_t           q_ctrl;
  logic [IdW-1:0]    head_id;
  logic [OccW-1:0]   occ;
  logic              q_full;
  logic              q_empty;

  logic              in_fire;
  logic              out_free;
  logic              exec_go;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign exec_go  = (state_q == SExec) && out_free;

  fcs_wait_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_wait_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .push_id_i   (id_q),
    .head_id_o   (head_id),
    .occupancy_o (occ),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_fire) state_d = SExec;
      SExec:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Execution of the registered request.
  always_comb begin
    q_ctrl     = '0;
    count_d    = count_q;
    granted_d  = 1'b0;
    grant_id_d = '0;
    status_d   = StatOk;
    waiting_d  = WaitW'(occ);

    if (exec_go) begin
      case (op_q)
        OpAcquire: begin
          if (count_q != '0) begin
            count_d    = count_q - 1'b1;
            granted_d  = 1'b1;
            grant_id_d = id_q;
          end else if (!q_full) begin
            q_ctrl.push = 1'b1;
            status_d    = StatQueued;
            waiting_d   = WaitW'(occ + 1'b1);
          end else begin
            status_d = StatDropped;
          end
        end
        OpRelease: begin
          if (!q_empty) begin
            q_ctrl.pop = 1'b1;
            granted_d  = 1'b1;
            grant_id_d = head_id;
            waiting_d  = WaitW'(occ - 1'b1);
          end else if (count_q < MaxTokens) begin
            count_d = count_q + 1'b1;
          end else begin
            status_d = StatSaturated;
          end
        end
        default: ;
      endcase
    end

    // A configuration write reloads the count and empties the queue.
    if (cfg_we_i) begin
      q_ctrl.clear = 1'b1;
      count_d      = (cfg_wdata_i > MaxTokens) ? MaxTokens : cfg_wdata_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= op_e'(req_i.opcode);
      id_q <= req_i.requester_id;
    end
    if (exec_go) begin
      granted_q  <= granted_d;
      grant_id_q <= grant_id_d;
      status_q   <= status_d;
      tokens_q   <= count_d;
      waiting_q  <= waiting_d;
    end
  end

  assign req_i.ready         = (state_q == SIdle);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted       = granted_q;
  assign rsp_o.grant_id      = grant_id_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.tokens_left   = tokens_q;
  assign rsp_o.waiting_count = waiting_q;

  // Waiters exist only while no token is left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.tokens_left == '0) || (rsp_o.waiting_count == '0))
    else $error("tokens left while requesters wait");

  // A request being executed with a free output always yields a response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> (state_q == SIdle) && rsp_o.valid)
    else $error("executed request produced no response");

  // A queue never pushes and pops in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_ctrl.push && q_ctrl.pop))
    else $error("wait queue push and pop together");

  // A dropped or queued acquire grants nothing, and no grant carries no id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.granted |-> (rsp_o.grant_id == '0))
    else $error("grant id set without a grant");

  // A grant from a release pops exactly one waiter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && q_ctrl.pop && !cfg_we_i |=> (occ == $past(occ) - 1'b1))
    else $error("release grant did not pop the queue");

endmodule

### rtl/core/fcs_wait_queue.sv
// Circular wait queue of requester ids held in a synchronous memory.
`timescale 1ns / 1ps
module fcs_wait_queue
  import fcs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  q_ctrl_t                              ctrl_i,
  input  logic [IdW-1:0]                       push_id_i,
  output logic [IdW-1:0]                       head_id_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     occupancy_o,
  output logic                                 full_o,
  output logic                                 empty_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned OccW  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(QUEUE_DEPTH - 1);
  localparam logic [OccW-1:0]  DepthOcc = OccW'(QUEUE_DEPTH);

  logic [IdW-1:0]   mem [QUEUE_DEPTH];
  logic [IdW-1:0]   head_rd_q;
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [OccW-1:0]  occ_q, occ_d;

  // Pointer and occupancy updates; clear empties the queue.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end else begin
      if (ctrl_i.push) begin
        tail_d = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
        occ_d  = occ_q + 1'b1;
      end
      if (ctrl_i.pop) begin
        head_d = (head_q == LastSlot) ? '0 : head_q + 1'b1;
        occ_d  = occ_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  // Memory write port at the tail.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem[tail_q] <= push_id_i;
    end
  end

  // Registered read port, always following the head slot.
  always_ff @(posedge clk_i) begin
    head_rd_q <= mem[head_q];
  end

  assign head_id_o   = head_rd_q;
  assign occupancy_o = occ_q;
  assign full_o      = (occ_q == DepthOcc);
  assign empty_o     = (occ_q == '0);

endmodule

### tb/tb_top.sv
// Self-checking testbench of the FIFO counting semaphore unit.
`timescale 1ns / 1ps
module tb_top;
  import fcs_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned PhaseWords = 78;

  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] id;
  } req_word_t;

  typedef struct packed {
    logic              granted;
    logic [IdW-1:0]    grant_id;
    status_e           status;
    logic [CountW-1:0] tokens;
    logic [WaitW-1:0]  waiting;
  } rsp_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  fcs_req_if req_if ();
  fcs_rsp_if rsp_if ();

  fifo_counting_semaphore_unit #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Words waiting to be sent and responses still owed by the block.
  req_word_t pending_req[$];
  rsp_word_t expected_rsp[$];

  // Predicted semaphore state: token count and the ids waiting in order.
  logic [CountW-1:0] token_cnt;
  logic [IdW-1:0]    waiters[$];

  int unsigned errors;
  int unsigned req_taken;
  int unsigned rsp_checked;
  int unsigned status_hits[4];
  int unsigned grants;
  int unsigned settings_used;
  int unsigned idle_cycles;
  int unsigned rsp_drained;
  int unsigned hold_left;
  bit          steady;

  always #2 clk_i = ~clk_i;

  // Apply one request word to the predicted state and return its response.
  function automatic rsp_word_t semaphore_step(req_word_t w);
    rsp_word_t r;
    r.granted  = 1'b0;
    r.grant_id = '0;
    r.status   = StatOk;
    if (w.op == OpAcquire) begin
      if (token_cnt != 0) begin
        token_cnt  = token_cnt - 1'b1;
        r.granted  = 1'b1;
        r.grant_id = w.id;
      end else if (waiters.size() < QueueDepth) begin
        waiters.push_back(w.id);
        r.status = StatQueued;
      end else begin
        r.status = StatDropped;
      end
    end else begin
      if (waiters.size() != 0) begin
        r.grant_id = waiters.pop_front();
        r.granted  = 1'b1;
      end else if (token_cnt != MaxTokens) begin
        token_cnt = token_cnt + 1'b1;
      end else begin
        r.status = StatSaturated;
      end
    end
    r.tokens  = token_cnt;
    r.waiting = WaitW'(waiters.size());
    status_hits[r.status]++;
    if (r.granted) grants++;
    return r;
  endfunction

  // Request driver: holds a word until it is taken, idles now and then.
  always @(posedge clk_i or negedge rst_ni) begin
    req_word_t sent;
    bit        offer;
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.opcode       <= OpAcquire;
      req_if.requester_id <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        sent = pending_req.pop_front();
        expected_rsp.push_back(semaphore_step(sent));
        req_taken++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        offer = (pending_req.size() != 0) && (steady || $urandom_range(99) >= 7);
        if (offer) begin
          req_if.valid        <= 1'b1;
          req_if.opcode       <= pending_req[0].op;
          req_if.requester_id <= pending_req[0].id;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response receiver: random stalls plus two long hold-offs that back the
  // block up into its request port.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_drained = 0;
      hold_left   = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_drained++;
        if (rsp_drained == 150 || rsp_drained == 450) hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  // Response checker: compares each word with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_word_t want;
    rsp_word_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.granted  = rsp_if.granted;
      got.grant_id = rsp_if.grant_id;
      got.status   = status_e'(rsp_if.status);
      got.tokens   = rsp_if.tokens_left;
      got.waiting  = rsp_if.waiting_count;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: response word with no request outstanding", $realtime);
      end else begin
        want = expected_rsp.pop_front();
        rsp_checked++;
        if (got.granted !== want.granted || got.grant_id !== want.grant_id ||
            got.status !== want.status || got.tokens !== want.tokens ||
            got.waiting !== want.waiting) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: word %0d expected g=%0b id=%0d st=%0d tok=%0d wait=%0d,",
                     $realtime, rsp_checked, want.granted, want.grant_id,
                     want.status, want.tokens, want.waiting);
            $display("    got g=%0b id=%0d st=%0d tok=%0d wait=%0d",
                     got.granted, got.grant_id, got.status, got.tokens,
                     got.waiting);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Timeout: no word moved for %0d cycles", IdleLimit);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic add_word(input op_e op, input logic [IdW-1:0] id);
    req_word_t w;
    w.op = op;
    w.id = id;
    pending_req.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_req.size() != 0 || expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Load the token count while the block is idle; this also empties the queue.
  task automatic load_tokens(input logic [CountW-1:0] value);
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    token_cnt = (value > MaxTokens) ? MaxTokens : value;
    waiters.delete();
    settings_used++;
  endtask

  // Random words in bursts that lean toward acquires, releases or neither,
  // so the queue fills up and the count climbs to saturation.
  task automatic queue_random_words(input int unsigned n);
    int unsigned left;
    int unsigned burst;
    int unsigned acq_pct;
    left = n;
    @(negedge clk_i);
    while (left > 0) begin
      burst = $urandom_range(20, 1);
      if (burst > left) burst = left;
      case ($urandom_range(2))
        0:       acq_pct = 10;
        1:       acq_pct = 50;
        default: acq_pct = 90;
      endcase
      repeat (burst)
        add_word(($urandom_range(99) < acq_pct) ? OpAcquire : OpRelease,
                 IdW'($urandom_range(15)));
      left -= burst;
    end
  endtask

  initial begin
    logic [CountW-1:0] phase_tokens[8];
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    token_cnt           = '0;
    steady              = 1'b0;
    phase_tokens = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd0, 8'd3, 8'd128, 8'd0};
    phase_tokens[4] = CountW'($urandom_range(255));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset no token is free: both acquires wait, releases hand off in
    // order, and the last release with nobody waiting adds a token.
    @(negedge clk_i);
    add_word(OpAcquire, 4'd0);
    add_word(OpAcquire, 4'd15);
    add_word(OpRelease, 4'd15);
    add_word(OpRelease, 4'd0);
    add_word(OpRelease, 4'd9);
    wait_drained();

    // Full count: a release saturates, an acquire takes one back.
    load_tokens(MaxTokens);
    @(negedge clk_i);
    add_word(OpRelease, 4'd0);
    add_word(OpAcquire, 4'd15);
    add_word(OpRelease, 4'd7);
    add_word(OpRelease, 4'd15);
    wait_drained();

    // Empty count: sixteen acquires fill the queue and the next is dropped.
    load_tokens('0);
    @(negedge clk_i);
    for (int i = 0; i < 17; i++) add_word(OpAcquire, IdW'(i));
    wait_drained();

    // Random phases, each from a fresh token setting; one runs with no idling.
    for (int p = 0; p < 8; p++) begin
      load_tokens(phase_tokens[p]);
      steady = (p == 3);
      queue_random_words(PhaseWords);
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      errors += expected_rsp.size();
      $display("%0d predicted responses never arrived", expected_rsp.size());
    end

    $display("Ran %0d requests over %0d token settings: %0d grants, %0d queued,",
             req_taken, settings_used, grants, status_hits[StatQueued]);
    $display("  %0d dropped, %0d saturated; checked %0d responses, %0d mismatches.",
             status_hits[StatDropped], status_hits[StatSaturated], rsp_checked,
             errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
